// ===== hdl/frpr_pkg.sv =====
// package for the framed packet receiver: sizes, codes and controller/datapath structs
// no dependencies; all files but the in and out interfaces use it by scoped names
package frpr_pkg;

  localparam int MAX_PAYLOAD = 32;
  localparam int NUM_MSG     = 4;
  localparam int ADDR_W      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 17;

  localparam logic [7:0] PREAMBLE = 8'hAA;

  // configuration register fields
  localparam int MSG_EN_BIT = 16;

  // commands from controller to datapath, each valid for one transfer
  typedef struct packed {
    logic start_frame;
    logic take_id;
    logic take_len;
    logic take_data;
    logic take_sum_lo;
    logic start_drain;
  } frpr_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic is_preamble;
    logic pair_ok;
    logic left_zero;
    logic left_one;
    logic sum_ok;
    logic drain_busy;
  } frpr_status_t;

endpackage

// ===== hdl/frpr_in_if.sv =====
// received byte channel, one byte per transfer
// no dependencies; the byte width is fixed at eight bits
interface frpr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ===== hdl/frpr_out_if.sv =====
// payload result channel, one payload byte per transfer
// fixed field widths of the result item
interface frpr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] msg_id;
  logic [6:0] msg_length;
  logic [5:0] byte_index;
  logic [7:0] payload_byte;
  logic       last;

  modport source (output valid, output msg_id, output msg_length, output byte_index,
                  output payload_byte, output last, input ready);
  modport sink   (input valid, input msg_id, input msg_length, input byte_index,
                  input payload_byte, input last, output ready);
endinterface

// ===== hdl/frpr_cfg_if.sv =====
// configuration write channel: register index and write data
// widths from frpr_pkg
interface frpr_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [frpr_pkg::CFG_IDX_W-1:0]   index;
  logic [frpr_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/frpr_ctrl.sv =====
// frame parser controller: phase state machine and input ready
// depends on frpr_pkg command and status structs
module frpr_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  frpr_pkg::frpr_status_t st,
  output frpr_pkg::frpr_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_HUNT,
    ST_ID,
    ST_LEN,
    ST_DATA,
    ST_SUM_LO,
    ST_SUM_HI,
    ST_DRAIN
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r, in_ready_nxt;
  logic   accept;

  assign accept   = in_valid && in_ready_r;
  assign in_ready = in_ready_r;

  // next phase and datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_HUNT: begin
        if (accept && st.is_preamble) begin
          cmd.start_frame = 1'b1;
          state_nxt       = ST_ID;
        end
      end
      ST_ID: begin
        // repeated preambles are skipped here
        if (accept && !st.is_preamble) begin
          cmd.take_id = 1'b1;
          state_nxt   = ST_LEN;
        end
      end
      ST_LEN: begin
        if (accept) begin
          if (st.pair_ok) begin
            cmd.take_len = 1'b1;
            state_nxt    = ST_DATA;
          end else begin
            state_nxt = ST_HUNT;
          end
        end
      end
      ST_DATA: begin
        if (accept) begin
          if (st.left_zero) begin
            // zero length frame: byte is swallowed
            state_nxt = ST_HUNT;
          end else begin
            cmd.take_data = 1'b1;
            if (st.left_one) begin
              state_nxt = ST_SUM_LO;
            end
          end
        end
      end
      ST_SUM_LO: begin
        if (accept) begin
          cmd.take_sum_lo = 1'b1;
          state_nxt       = ST_SUM_HI;
        end
      end
      ST_SUM_HI: begin
        if (accept) begin
          if (st.sum_ok) begin
            cmd.start_drain = 1'b1;
            state_nxt       = ST_DRAIN;
          end else begin
            state_nxt = ST_HUNT;
          end
        end
      end
      ST_DRAIN: begin
        if (!st.drain_busy) begin
          state_nxt = ST_HUNT;
        end
      end
      default: begin
        state_nxt = ST_HUNT;
      end
    endcase
    in_ready_nxt = (state_nxt != ST_DRAIN);
  end

  // state and registered ready
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_HUNT;
      in_ready_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= in_ready_nxt;
    end
  end

  // input is held off for the whole payload read-out
  a_ready_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |-> !in_ready_r)
    else $error("input ready during read-out");

  // ready returns whenever the parser is not reading out
  a_ready_parse: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_DRAIN) |-> in_ready_r)
    else $error("input stalled outside read-out");

  // at most one datapath command per transfer
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("conflicting datapath commands");

endmodule

// ===== hdl/frpr_dp.sv =====
// frame datapath: message table, header/sum registers, payload memory, result register
// depends on frpr_pkg and the output and configuration channel interfaces
module frpr_dp (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [7:0]             rx_byte,
  input  frpr_pkg::frpr_cmd_t    cmd,
  output frpr_pkg::frpr_status_t st,
  frpr_out_if.source             out_ch,
  frpr_cfg_if.sink               cfg_ch
);

  logic [frpr_pkg::CFG_DATA_W-1:0] msg_tab_r [frpr_pkg::NUM_MSG];

  logic [7:0]                    frame_id_r;
  logic [7:0]                    frame_len_r;
  logic [frpr_pkg::CNT_W-1:0]    left_r;
  logic [frpr_pkg::ADDR_W-1:0]   wpos_r;
  logic [15:0]                   sum_r;
  logic [7:0]                    sum_lo_r;
  logic [7:0]                    pay_mem [frpr_pkg::MAX_PAYLOAD];

  logic                          drain_r;
  logic [frpr_pkg::CNT_W-1:0]    rd_cnt_r;

  logic                          out_valid_r;
  logic [7:0]                    out_id_r;
  logic [6:0]                    out_len_r;
  logic [5:0]                    out_idx_r;
  logic [7:0]                    out_byte_r;
  logic                          out_last_r;

  logic                          pair_hit;
  logic                          rd_go;
  logic                          rd_last;
  logic [15:0]                   sum_add;

  // configuration writes, indexes past the table are dropped
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < frpr_pkg::NUM_MSG; k++) begin
        msg_tab_r[k] <= '0;
      end
    end else if (cfg_ch.valid &&
                 (cfg_ch.index < frpr_pkg::CFG_IDX_W'(frpr_pkg::NUM_MSG))) begin
      msg_tab_r[cfg_ch.index[1:0]] <= cfg_ch.data;
    end
  end

  // id and length pair lookup against enabled table entries
  always_comb begin
    pair_hit = 1'b0;
    for (int k = 0; k < frpr_pkg::NUM_MSG; k++) begin
      if (msg_tab_r[k][frpr_pkg::MSG_EN_BIT] &&
          (msg_tab_r[k][15:8] == frame_id_r) &&
          (msg_tab_r[k][7:0] == rx_byte)) begin
        pair_hit = 1'b1;
      end
    end
  end

  assign sum_add = sum_r + {8'd0, rx_byte};

  // status to controller
  always_comb begin
    st.is_preamble = (rx_byte == frpr_pkg::PREAMBLE);
    st.pair_ok     = pair_hit && (rx_byte <= 8'(frpr_pkg::MAX_PAYLOAD));
    st.left_zero   = (left_r == '0);
    st.left_one    = (left_r == frpr_pkg::CNT_W'(1));
    st.sum_ok      = (sum_r == {rx_byte, sum_lo_r});
    st.drain_busy  = drain_r;
  end

  // header, count and running sum registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_id_r  <= '0;
      frame_len_r <= '0;
      left_r      <= '0;
      wpos_r      <= '0;
      sum_r       <= '0;
      sum_lo_r    <= '0;
    end else begin
      if (cmd.start_frame) begin
        frame_id_r  <= '0;
        frame_len_r <= '0;
        left_r      <= '0;
        wpos_r      <= '0;
        sum_lo_r    <= '0;
        sum_r       <= {8'd0, rx_byte};
      end
      if (cmd.take_id) begin
        frame_id_r <= rx_byte;
        sum_r      <= sum_add;
      end
      if (cmd.take_len) begin
        frame_len_r <= rx_byte;
        left_r      <= frpr_pkg::CNT_W'(rx_byte);
        sum_r       <= sum_add;
      end
      if (cmd.take_data) begin
        sum_r  <= sum_add;
        wpos_r <= wpos_r + frpr_pkg::ADDR_W'(1);
        left_r <= left_r - frpr_pkg::CNT_W'(1);
      end
      if (cmd.take_sum_lo) begin
        sum_lo_r <= rx_byte;
      end
    end
  end

  // payload memory write port
  always_ff @(posedge clk) begin
    if (cmd.take_data) begin
      pay_mem[wpos_r] <= rx_byte;
    end
  end

  // read-out sequencer: one memory read per free result slot
  assign rd_go   = drain_r && (!out_valid_r || out_ch.ready);
  assign rd_last = ((8'(rd_cnt_r) + 8'd1) == frame_len_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drain_r     <= 1'b0;
      rd_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.start_drain) begin
        drain_r  <= 1'b1;
        rd_cnt_r <= '0;
      end else if (rd_go) begin
        rd_cnt_r <= rd_cnt_r + frpr_pkg::CNT_W'(1);
        if (rd_last) begin
          drain_r <= 1'b0;
        end
      end
      if (rd_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result register, doubles as the memory read data register
  always_ff @(posedge clk) begin
    if (rd_go) begin
      out_byte_r <= pay_mem[rd_cnt_r[frpr_pkg::ADDR_W-1:0]];
      out_id_r   <= frame_id_r;
      out_len_r  <= frame_len_r[6:0];
      out_idx_r  <= 6'(rd_cnt_r);
      out_last_r <= rd_last;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.msg_id       = out_id_r;
  assign out_ch.msg_length   = out_len_r;
  assign out_ch.byte_index   = out_idx_r;
  assign out_ch.payload_byte = out_byte_r;
  assign out_ch.last         = out_last_r;

  // read-out never passes the frame length
  a_rd_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    drain_r |-> (8'(rd_cnt_r) < frame_len_r))
    else $error("read-out past frame length");

  // a payload byte is only stored while bytes are still expected
  a_data_counted: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take_data |-> (left_r != '0))
    else $error("payload byte with no bytes left");

  // the marked result is the final byte of its frame
  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> ((7'(out_idx_r) + 7'd1) == out_len_r))
    else $error("last flag off the final byte");

endmodule

// ===== hdl/framed_packet_receiver_sum16_core.sv =====
// top level of the framed packet receiver with 16-bit additive checksum
// depends on frpr_pkg, the channel interfaces, frpr_ctrl and frpr_dp
//
//  channel | dir | transfer moves
//  --------+-----+-------------------------------------------------------------
//  in_ch   | in  | rx_byte, one received byte
//  out_ch  | out | msg_id, msg_length, byte_index, payload_byte, last
//  cfg_ch  | in  | index 0..3 selects known_msg_0..3, data holds the 17-bit entry
//
// header, payload and checksum bytes are taken at one byte per cycle
// after a good checksum input stalls while the payload is read out of the
// payload memory, one byte per cycle while out_ch is ready
// out_ch stalls hold the read-out; a finished result waits in the output register
// synchronous active-low reset clears the table and parser; no memory clear pass
// cfg_ch is always ready
module framed_packet_receiver_sum16_core (
  input  logic        clk,
  input  logic        rst_n,
  frpr_in_if.sink     in_ch,
  frpr_out_if.source  out_ch,
  frpr_cfg_if.sink    cfg_ch
);

  frpr_pkg::frpr_cmd_t    cmd;
  frpr_pkg::frpr_status_t st;

  // phase controller
  frpr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  // datapath with payload memory and result register
  frpr_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .rx_byte (in_ch.rx_byte),
    .cmd     (cmd),
    .st      (st),
    .out_ch  (out_ch),
    .cfg_ch  (cfg_ch)
  );

endmodule

// ===== bench/frpr_frame_checker.sv =====
// frame checker for the framed packet receiver: watches the three channels,
// predicts the payload transfers and compares them field by field
// depends on frpr_pkg and the channel interfaces frpr_in_if, frpr_out_if, frpr_cfg_if
module frpr_frame_checker (
  input  logic  clk,
  input  logic  rst_n,
  frpr_in_if    in_ch,
  frpr_out_if   out_ch,
  frpr_cfg_if   cfg_ch,
  output int    fail_count,
  output int    beats_pending,
  output int    beats_checked,
  output int    frames_passed
);

  typedef enum logic [2:0] {
    HUNT,
    WANT_ID,
    WANT_LEN,
    PAYLOAD,
    SUM_LO,
    SUM_HI
  } rx_phase_t;

  typedef struct {
    logic [7:0] msg_id;
    logic [6:0] msg_length;
    logic [5:0] byte_index;
    logic [7:0] payload_byte;
    logic       last;
  } payload_beat_t;

  // predicted parser state
  rx_phase_t   rx_phase;
  logic [7:0]  hdr_id;
  logic [7:0]  hdr_len;
  logic [7:0]  remaining;
  logic [5:0]  wr_ptr;
  logic [15:0] sum_acc;
  logic [7:0]  sum_lo_rx;
  logic [7:0]  frame_buf [frpr_pkg::MAX_PAYLOAD];
  logic [frpr_pkg::CFG_DATA_W-1:0] known_tbl [frpr_pkg::NUM_MSG];

  payload_beat_t payload_q [$];
  int fails  = 0;
  int checks = 0;
  int passed = 0;

  task automatic clear_parser();
    hdr_id    = '0;
    hdr_len   = '0;
    remaining = '0;
    wr_ptr    = '0;
    sum_lo_rx = '0;
    foreach (frame_buf[k]) frame_buf[k] = '0;
  endtask

  // enabled table entry with this id and length, length within the store
  function automatic bit pair_enabled(logic [7:0] id, logic [7:0] len);
    bit hit;
    hit = 1'b0;
    if (len <= frpr_pkg::MAX_PAYLOAD) begin
      foreach (known_tbl[k]) begin
        if (known_tbl[k][frpr_pkg::MSG_EN_BIT] && known_tbl[k][15:8] == id &&
            known_tbl[k][7:0] == len)
          hit = 1'b1;
      end
    end
    return hit;
  endfunction

  // advance the parser by one received byte, queue any payload it releases
  task automatic take_byte(input logic [7:0] b);
    int n;
    payload_beat_t beat;
    case (rx_phase)
      HUNT: begin
        if (b == frpr_pkg::PREAMBLE) begin
          clear_parser();
          sum_acc  = {8'h00, b};
          rx_phase = WANT_ID;
        end
      end
      WANT_ID: begin
        // repeated preambles are skipped
        if (b != frpr_pkg::PREAMBLE) begin
          hdr_id   = b;
          sum_acc  = sum_acc + {8'h00, b};
          rx_phase = WANT_LEN;
        end
      end
      WANT_LEN: begin
        hdr_len = b;
        if (pair_enabled(hdr_id, b)) begin
          sum_acc   = sum_acc + {8'h00, b};
          remaining = b;
          rx_phase  = PAYLOAD;
        end else begin
          rx_phase = HUNT;
        end
      end
      PAYLOAD: begin
        // zero length frame swallows one byte and goes back to hunting
        if (remaining != 0) begin
          if (wr_ptr < frpr_pkg::MAX_PAYLOAD) frame_buf[wr_ptr] = b;
          sum_acc   = sum_acc + {8'h00, b};
          wr_ptr    = wr_ptr + 6'd1;
          remaining = remaining - 8'd1;
          if (remaining == 0) rx_phase = SUM_LO;
        end else begin
          rx_phase = HUNT;
        end
      end
      SUM_LO: begin
        sum_lo_rx = b;
        rx_phase  = SUM_HI;
      end
      SUM_HI: begin
        if (sum_acc == {b, sum_lo_rx}) begin
          n = (hdr_len > frpr_pkg::MAX_PAYLOAD) ? frpr_pkg::MAX_PAYLOAD : hdr_len;
          for (int k = 0; k < n; k++) begin
            beat.msg_id       = hdr_id;
            beat.msg_length   = hdr_len[6:0];
            beat.byte_index   = 6'(k);
            beat.payload_byte = frame_buf[k];
            beat.last         = (k == n - 1);
            payload_q.push_back(beat);
          end
          passed++;
        end
        rx_phase = HUNT;
      end
      default: rx_phase = HUNT;
    endcase
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fails++;
    end
  endtask

  // compare one payload transfer with the oldest prediction
  task automatic compare_beat();
    payload_beat_t want;
    if (payload_q.size() == 0) begin
      $error("payload transfer with nothing predicted: id 0x%0h index %0d byte 0x%0h",
             out_ch.msg_id, out_ch.byte_index, out_ch.payload_byte);
      fails++;
    end else begin
      want = payload_q.pop_front();
      check_field("msg_id", want.msg_id, out_ch.msg_id);
      check_field("msg_length", {1'b0, want.msg_length}, {1'b0, out_ch.msg_length});
      check_field("byte_index", {2'b00, want.byte_index}, {2'b00, out_ch.byte_index});
      check_field("payload_byte", want.payload_byte, out_ch.payload_byte);
      check_field("last", {7'd0, want.last}, {7'd0, out_ch.last});
      checks++;
    end
  endtask

  // sample every channel at the clock edge
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_parser();
      rx_phase = HUNT;
      sum_acc  = '0;
      foreach (known_tbl[k]) known_tbl[k] = '0;
      payload_q.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) compare_beat();
      if (cfg_ch.valid && cfg_ch.ready && cfg_ch.index < frpr_pkg::NUM_MSG)
        known_tbl[cfg_ch.index[1:0]] = cfg_ch.data;
      if (in_ch.valid && in_ch.ready) take_byte(in_ch.rx_byte);
    end
    fail_count    <= fails;
    beats_pending <= payload_q.size();
    beats_checked <= checks;
    frames_passed <= passed;
  end

endmodule

// ===== bench/framed_packet_receiver_sum16_core_tb.sv =====
// testbench top for framed_packet_receiver_sum16_core: clock, reset, table writes,
// byte stimulus with random idling and the verdict
// depends on frpr_pkg, the channel interfaces, the block and frpr_frame_checker
module framed_packet_receiver_sum16_core_tb;

  localparam logic [frpr_pkg::CFG_IDX_W-1:0] KNOWN_MSG_0    = 3'd0;
  localparam logic [frpr_pkg::CFG_IDX_W-1:0] KNOWN_MSG_1    = 3'd1;
  localparam logic [frpr_pkg::CFG_IDX_W-1:0] KNOWN_MSG_2    = 3'd2;
  localparam logic [frpr_pkg::CFG_IDX_W-1:0] KNOWN_MSG_3    = 3'd3;
  localparam logic [frpr_pkg::CFG_IDX_W-1:0] UNMAPPED_INDEX = 3'd5;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 2 * frpr_pkg::MAX_PAYLOAD + 8;

  logic clk;
  logic rst_n;

  frpr_in_if  in_ch();
  frpr_out_if out_ch();
  frpr_cfg_if cfg_ch();

  int fail_count;
  int beats_pending;
  int beats_checked;
  int frames_passed;

  bit idle_on      = 1'b1;
  bit idle_allowed = 1'b1;
  bit stall_on     = 1'b1;
  int cycle_cnt   = 0;
  int bytes_sent  = 0;
  int frames_sent = 0;
  logic [frpr_pkg::CFG_DATA_W-1:0] msg_table [frpr_pkg::NUM_MSG];

  framed_packet_receiver_sum16_core DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  frpr_frame_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_ch        (cfg_ch),
    .fail_count    (fail_count),
    .beats_pending (beats_pending),
    .beats_checked (beats_checked),
    .frames_passed (frames_passed)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("framed_packet_receiver_sum16_core regression: fail");
      $finish;
    end
  end

  // result side back-pressure in random bursts
  initial begin
    out_ch.ready <= 1'b1;
    forever begin
      repeat ($urandom_range(1, 40)) @(posedge clk);
      if (stall_on && $urandom_range(0, 1) == 1) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end
    end
  end

  // one byte transfer, with an occasional idle burst in front
  task automatic send_byte(input logic [7:0] b);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  // one table write transfer; the caller lowers valid after the batch
  task automatic cfg_put(input logic [frpr_pkg::CFG_IDX_W-1:0] idx,
                         input logic [frpr_pkg::CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  task automatic load_table(input logic [frpr_pkg::CFG_DATA_W-1:0] d0,
                            input logic [frpr_pkg::CFG_DATA_W-1:0] d1,
                            input logic [frpr_pkg::CFG_DATA_W-1:0] d2,
                            input logic [frpr_pkg::CFG_DATA_W-1:0] d3,
                            input bit spare_write);
    cfg_put(KNOWN_MSG_0, d0);
    cfg_put(KNOWN_MSG_1, d1);
    cfg_put(KNOWN_MSG_2, d2);
    cfg_put(KNOWN_MSG_3, d3);
    if (spare_write) cfg_put(UNMAPPED_INDEX, 17'($urandom()));
    cfg_ch.valid <= 1'b0;
    msg_table[0] = d0;
    msg_table[1] = d1;
    msg_table[2] = d2;
    msg_table[3] = d3;
  endtask

  // input idle until every payload has come out and the parser has gone quiet
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (beats_pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // preambles, header, payload and checksum; cut stops the frame early
  task automatic send_frame(input logic [7:0] id, input logic [7:0] len, input int n_pre,
                            input bit corrupt, input int cut);
    logic [15:0] chk;
    logic [7:0]  b;
    int          n_data;
    frames_sent++;
    chk = {8'h00, frpr_pkg::PREAMBLE} + {8'h00, id} + {8'h00, len};
    repeat (n_pre) send_byte(frpr_pkg::PREAMBLE);
    send_byte(id);
    send_byte(len);
    if (len > frpr_pkg::MAX_PAYLOAD) n_data = 4;
    else if (len == 0) n_data = 1;
    else n_data = len;
    if (cut < n_data) n_data = cut;
    for (int k = 0; k < n_data; k++) begin
      b = ($urandom_range(0, 7) == 0) ? frpr_pkg::PREAMBLE : 8'($urandom_range(0, 255));
      chk = chk + {8'h00, b};
      send_byte(b);
    end
    if (len != 0 && len <= frpr_pkg::MAX_PAYLOAD && cut >= len) begin
      if (corrupt) chk = chk ^ (16'h0001 << $urandom_range(0, 15));
      send_byte(chk[7:0]);
      send_byte(chk[15:8]);
    end
  endtask

  // mostly well-formed frames from the table, the rest broken frames and noise
  task automatic random_sequence();
    int r;
    int e;
    r = $urandom_range(0, 99);
    e = $urandom_range(0, frpr_pkg::NUM_MSG - 1);
    if (r < 70) begin
      send_frame(msg_table[e][15:8], msg_table[e][7:0], (r < 10) ? $urandom_range(2, 3) : 1,
                 $urandom_range(0, 6) == 0, 255);
    end else if (r < 80) begin
      send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 40)), 1, 1'b0, 255);
    end else if (r < 88) begin
      send_frame(msg_table[e][15:8], msg_table[e][7:0], 1, 1'b0,
                 $urandom_range(0, msg_table[e][7:0]));
    end else begin
      repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic random_phase(input int target);
    int start;
    start = bytes_sent;
    while (bytes_sent - start < target) begin
      idle_on = idle_allowed && ($urandom_range(0, 3) != 0);
      random_sequence();
    end
  endtask

  function automatic logic [frpr_pkg::CFG_DATA_W-1:0] random_entry();
    return {1'b1, 8'($urandom_range(0, 255)), 8'($urandom_range(1, 8))};
  endfunction

  initial begin
    logic [frpr_pkg::CFG_DATA_W-1:0] dup;
    rst_n          <= 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.rx_byte  <= '0;
    cfg_ch.valid   <= 1'b0;
    cfg_ch.index   <= '0;
    cfg_ch.data    <= '0;
    foreach (msg_table[k]) msg_table[k] = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // table still cleared: a zero pair must not be taken
    send_frame(8'h00, 8'h00, 1, 1'b0, 255);
    settle();

    // directed: repeated preambles, zero length, disabled entry, bad and good checksum
    load_table({1'b1, 8'h00, 8'h01}, {1'b1, 8'hFF, 8'h00},
               {1'b1, 8'h5A, 8'h03}, {1'b0, 8'h33, 8'h01}, 1'b0);
    send_frame(8'h00, 8'h01, 3, 1'b0, 255);
    send_frame(8'hFF, 8'h00, 1, 1'b0, 255);
    send_frame(8'h33, 8'h01, 1, 1'b0, 255);
    send_frame(8'h5A, 8'h03, 1, 1'b1, 255);
    send_frame(8'h5A, 8'h03, 1, 1'b0, 255);
    random_phase(10);
    settle();

    // random short entries, two of them equal
    dup = random_entry();
    load_table(random_entry(), random_entry(), dup, dup, 1'b0);
    random_phase(15);
    settle();

    // extremes: all ones, longest frame, one past the longest, spare index
    load_table(17'h1FFFF, {1'b1, 8'h80, 8'(frpr_pkg::MAX_PAYLOAD)},
               {1'b1, 8'h01, 8'(frpr_pkg::MAX_PAYLOAD + 1)}, {1'b1, 8'h7F, 8'h01}, 1'b1);
    send_frame(8'h80, 8'(frpr_pkg::MAX_PAYLOAD), 1, 1'b0, 255);
    send_frame(8'h01, 8'(frpr_pkg::MAX_PAYLOAD + 1), 1, 1'b0, 255);
    random_phase(15);
    settle();

    // last stretch at full rate on both sides
    load_table(random_entry(), random_entry(), random_entry(), 17'h00000, 1'b0);
    stall_on     = 1'b0;
    idle_allowed = 1'b0;
    random_phase(15);
    settle();

    $display("covered %0d byte transfers in %0d frames over five table settings",
             bytes_sent, frames_sent);
    $display("%0d frames passed the checksum, %0d payload transfers compared",
             frames_passed, beats_checked);
    if (beats_pending != 0)
      $error("%0d predicted payload transfers never arrived", beats_pending);
    if (fail_count == 0 && beats_pending == 0) begin
      $display("framed_packet_receiver_sum16_core regression: pass");
    end else begin
      $display("framed_packet_receiver_sum16_core regression: fail");
    end
    $finish;
  end

endmodule

// ===== framed_packet_receiver_sum16_core.f =====
hdl/frpr_pkg.sv
hdl/frpr_in_if.sv
hdl/frpr_out_if.sv
hdl/frpr_cfg_if.sv
hdl/frpr_ctrl.sv
hdl/frpr_dp.sv
hdl/framed_packet_receiver_sum16_core.sv
bench/frpr_frame_checker.sv
bench/framed_packet_receiver_sum16_core_tb.sv
